@@ design/bdhe_pkg.sv @@
// Shared types and constants for the button debounce / hold event block.
// Used by bdhe_step and button_debounce_hold_events_core. No dependencies.
package bdhe_pkg;

   // History pattern matching
   localparam logic [15:0] PATTERN_MASK = 16'hF03F;
   localparam logic [15:0] RISE_PATTERN = 16'h003F;
   localparam logic [15:0] FALL_PATTERN = 16'hF000;
   localparam logic [15:0] HIST_ONES    = 16'hFFFF;
   localparam logic [15:0] HIST_ZEROS   = 16'h0000;

   // Event codes
   localparam logic [1:0] EV_NONE     = 2'd0;
   localparam logic [1:0] EV_PRESSED  = 2'd1;
   localparam logic [1:0] EV_RELEASED = 2'd2;
   localparam logic [1:0] EV_HOLD     = 2'd3;

   // Register indexes
   localparam logic [1:0] CSR_ACTIVE_LOW     = 2'd0;
   localparam logic [1:0] CSR_HOLD_DELAY_MS  = 2'd1;
   localparam logic [1:0] CSR_HOLD_REPEAT_MS = 2'd2;

   // Register reset values
   localparam logic        RST_ACTIVE_LOW     = 1'b1;
   localparam logic [15:0] RST_HOLD_DELAY_MS  = 16'd1000;
   localparam logic [15:0] RST_HOLD_REPEAT_MS = 16'd200;

   typedef struct packed {
      logic [15:0] history;
      logic        held;
      logic [31:0] next_hold_time;
   } btn_state_type;

   typedef struct packed {
      logic        active_low;
      logic [15:0] hold_delay_ms;
      logic [15:0] hold_repeat_ms;
   } btn_cfg_type;

endpackage

@@ design/bdhe_step.sv @@
// Next-state and event logic for one poll word.
// Depends on bdhe_pkg (state/config structs, patterns, event codes).
module bdhe_step
   import bdhe_pkg::*;
(
   input  btn_state_type state_cur,
   input  btn_cfg_type   cfg,
   input  logic          pin_level,
   input  logic [31:0]   now_ms,
   output btn_state_type state_nxt,
   output logic [1:0]    event_res
);

   logic [15:0] shifted;
   logic [15:0] hist_dn;
   logic [15:0] hist_up;
   logic        down_hit;
   logic        up_hit;
   logic        rise_a;
   logic        fall_a;
   logic        rise_b;
   logic        fall_b;

   always_comb begin
      shifted = {state_cur.history[14:0], pin_level};

      // down test on the freshly shifted history
      rise_a   = (shifted & PATTERN_MASK) == RISE_PATTERN;
      fall_a   = (shifted & PATTERN_MASK) == FALL_PATTERN;
      down_hit = cfg.active_low ? rise_a : fall_a;
      hist_dn  = down_hit ? (cfg.active_low ? HIST_ONES : HIST_ZEROS) : shifted;

      // up test sees the possibly rewritten history
      rise_b  = (hist_dn & PATTERN_MASK) == RISE_PATTERN;
      fall_b  = (hist_dn & PATTERN_MASK) == FALL_PATTERN;
      up_hit  = cfg.active_low ? fall_b : rise_b;
      hist_up = up_hit ? (cfg.active_low ? HIST_ZEROS : HIST_ONES) : hist_dn;

      state_nxt         = state_cur;
      state_nxt.history = hist_up;
      event_res         = EV_NONE;

      if (down_hit && !state_cur.held) begin
         state_nxt.history        = hist_dn;
         state_nxt.held           = 1'b1;
         state_nxt.next_hold_time = now_ms + {16'd0, cfg.hold_delay_ms};
         event_res                = EV_PRESSED;
      end else if (up_hit) begin
         state_nxt.held = 1'b0;
         event_res      = EV_RELEASED;
      end else if (state_cur.held && (now_ms >= state_cur.next_hold_time)) begin
         // no wrap handling on purpose: plain unsigned compare
         state_nxt.next_hold_time = state_cur.next_hold_time + {16'd0, cfg.hold_repeat_ms};
         event_res                = EV_HOLD;
      end
   end

endmodule

@@ design/button_debounce_hold_events_core.sv @@
// A word goes through the input register, then the result register, onto rsp_*.
// Throughput: one poll word per cycle unless rsp_stall holds a full result register;
// the debounce state loops through bdhe_step combinationally, so consecutive words never wait on each other.
// Reset (synchronous, active high): history, held flag and hold time clear,
// registers return to active_low=1, hold_delay_ms=1000, hold_repeat_ms=200.
// Depends on bdhe_pkg and bdhe_step.
module button_debounce_hold_events_core
   import bdhe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   // poll words in
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_pin_level,
   input  logic [31:0] req_now_ms,
   // event words out
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_event_res,
   // register writes
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   // ---------------------------------------------------------------
   // Register file
   // ---------------------------------------------------------------
   btn_cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.active_low     <= RST_ACTIVE_LOW;
         cfg_ff.hold_delay_ms  <= RST_HOLD_DELAY_MS;
         cfg_ff.hold_repeat_ms <= RST_HOLD_REPEAT_MS;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ACTIVE_LOW:     cfg_ff.active_low     <= csr_wdata[0];
            CSR_HOLD_DELAY_MS:  cfg_ff.hold_delay_ms  <= csr_wdata;
            CSR_HOLD_REPEAT_MS: cfg_ff.hold_repeat_ms <= csr_wdata;
            default: ;  // unused index, write dropped
         endcase
      end
   end

   // ---------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------
   logic        in_valid_ff;
   logic        in_level_ff;
   logic [31:0] in_now_ff;
   logic        advance;

   // output slot free or being drained this cycle
   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!req_stall && req_valid) begin
         in_level_ff <= req_pin_level;
         in_now_ff   <= req_now_ms;
      end
   end

   // ---------------------------------------------------------------
   // Debounce state and evaluation
   // ---------------------------------------------------------------
   btn_state_type state_ff;
   btn_state_type state_in;
   logic [1:0]    event_in;
   logic          commit;

   bdhe_step u_step (
      .state_cur (state_ff),
      .cfg       (cfg_ff),
      .pin_level (in_level_ff),
      .now_ms    (in_now_ff),
      .state_nxt (state_in),
      .event_res (event_in)
   );

   // state only moves when a word leaves the input register
   assign commit = in_valid_ff && advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (commit) begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------
   // Result register
   // ---------------------------------------------------------------
   logic       rsp_valid_ff;
   logic [1:0] rsp_event_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_event_ff <= event_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_event_res = rsp_event_ff;

   // ---------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------
   a_press_sets_held: assert property (@(posedge clock) disable iff (reset)
      (commit && event_in == EV_PRESSED) |=> state_ff.held)
      else $error("pressed word did not set held");

   a_release_clears_held: assert property (@(posedge clock) disable iff (reset)
      (commit && event_in == EV_RELEASED) |=> !state_ff.held)
      else $error("released word did not clear held");

   a_hold_needs_held: assert property (@(posedge clock) disable iff (reset)
      (commit && event_in == EV_HOLD) |-> (state_ff.held && in_now_ff >= state_ff.next_hold_time))
      else $error("hold event without armed hold");

   a_result_matches: assert property (@(posedge clock) disable iff (reset)
      commit |=> (rsp_valid && rsp_event_res == $past(event_in)))
      else $error("result register lost a word");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid && rsp_stall))
      else $error("input stalled with room to move");

endmodule
